@@ design/assert_macros.svh @@
// Assertion helpers for the PackBits encoder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is low.
`define PB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is low.
`define PB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pbrle_pkg.sv @@
`default_nettype none

package pbrle_pkg;

  localparam int MaxChunk       = 128;
  localparam int BytesPerResult = 8;
  localparam int MemDepth       = 256;

  typedef enum logic [1:0] {
    BSEL_HDR,
    BSEL_RUNV,
    BSEL_MEM
  } bsel_e;

  typedef enum logic {
    WSEL_BYTE,
    WSEL_RUNV
  } wsel_e;

  typedef struct packed {
    logic       push;
    bsel_e      bsel;
    logic [7:0] hdr;
    logic       we;
    wsel_e      wsel;
    logic [7:0] waddr;
    logic [7:0] raddr;
    logic       rv_load;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic eq_rv;
    logic eq_p1;
    logic eq_p2;
    logic line_end;
    logic byte_rdy;
    logic out_free;
    logic pk_empty;
  } sts_t;

endpackage

`default_nettype wire

@@ design/pbrle_if.sv @@
`default_nettype none

interface pbrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_end;

  modport source (output valid, output data_byte, output line_end, input ready);
  modport sink   (input valid, input data_byte, input line_end, output ready);
endinterface

interface pbrle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        last_of_item;
  logic        line_done;

  modport source (output valid, output packed_bytes, output byte_count,
                  output last_of_item, output line_done, input ready);
  modport sink   (input valid, input packed_bytes, input byte_count,
                  input last_of_item, input line_done, output ready);
endinterface

`default_nettype wire

@@ design/pbrle_dp.sv @@
`default_nettype none

module pbrle_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            line_end_i,
  input  wire pbrle_pkg::cmd_t cmd_i,
  output pbrle_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [63:0]          packed_bytes_o,
  output logic [3:0]           byte_count_o,
  output logic                 last_of_item_o,
  output logic                 line_done_o
);

  logic [7:0]  mem [pbrle_pkg::MemDepth];
  logic [7:0]  rdata_q;
  logic [7:0]  b_q, rv_q, p1_q, p2_q;
  logic        end_q;
  logic [63:0] pk_word_q;
  logic [3:0]  pk_cnt_q;
  logic [7:0]  wdata, obyte;
  logic        out_free, pk_full, load_full, load_flush;

  assign wdata = (cmd_i.wsel == pbrle_pkg::WSEL_RUNV) ? rv_q : b_q;

  always_comb begin
    unique case (cmd_i.bsel)
      pbrle_pkg::BSEL_RUNV: obyte = rv_q;
      pbrle_pkg::BSEL_MEM:  obyte = rdata_q;
      default:              obyte = cmd_i.hdr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= wdata;
    end
    rdata_q <= mem[cmd_i.raddr];
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign pk_full    = (pk_cnt_q == 4'(pbrle_pkg::BytesPerResult));
  assign load_full  = cmd_i.push && pk_full;
  assign load_flush = cmd_i.flush && !cmd_i.push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q            <= '0;
      end_q          <= 1'b0;
      rv_q           <= '0;
      p1_q           <= '0;
      p2_q           <= '0;
      pk_word_q      <= '0;
      pk_cnt_q       <= '0;
      out_valid_o    <= 1'b0;
      packed_bytes_o <= '0;
      byte_count_o   <= '0;
      last_of_item_o <= 1'b0;
      line_done_o    <= 1'b0;
    end else begin
      if (in_fire_i) begin
        b_q   <= data_byte_i;
        end_q <= line_end_i;
      end
      if (cmd_i.rv_load) begin
        rv_q <= b_q;
      end
      if (cmd_i.we) begin
        p2_q <= p1_q;
        p1_q <= wdata;
      end
      if (cmd_i.push) begin
        if (pk_full) begin
          pk_word_q <= {56'd0, obyte};
          pk_cnt_q  <= 4'd1;
        end else begin
          pk_word_q[{pk_cnt_q[2:0], 3'b000} +: 8] <= obyte;
          pk_cnt_q <= pk_cnt_q + 4'd1;
        end
      end else if (cmd_i.flush) begin
        pk_word_q <= '0;
        pk_cnt_q  <= '0;
      end
      if (load_full || load_flush) begin
        out_valid_o    <= 1'b1;
        packed_bytes_o <= pk_word_q;
        byte_count_o   <= pk_cnt_q;
        last_of_item_o <= load_flush;
        line_done_o    <= load_flush && end_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.eq_rv    = (b_q == rv_q);
    sts_o.eq_p1    = (b_q == p1_q);
    sts_o.eq_p2    = (b_q == p2_q);
    sts_o.line_end = end_q;
    sts_o.byte_rdy = !pk_full || out_free;
    sts_o.out_free = out_free;
    sts_o.pk_empty = (pk_cnt_q == 4'd0);
  end

endmodule

`default_nettype wire

@@ design/pbrle_ctrl.sv @@
`default_nettype none

module pbrle_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  output logic                 in_ready_o,
  input  wire pbrle_pkg::sts_t sts_i,
  output pbrle_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_WR2, S_RUN_HDR, S_RUN_VAL,
    S_LIT_HDR, S_LIT_RD, S_LIT_EM, S_FIN, S_FLUSH
  } state_e;

  state_e     state_q, state_d;
  logic       run_mode_q, run_mode_d, end_phase_q, end_phase_d;
  logic [7:0] run_len_q, run_len_d, cnt_q, cnt_d, head_q, head_d;
  logic [7:0] rd_q, rd_d, rem_q, rem_d, chk_q, chk_d, hdr_q, hdr_d;
  logic [7:0] chunk;

  assign chunk      = (rem_q > 8'(pbrle_pkg::MaxChunk)) ? 8'(pbrle_pkg::MaxChunk) : rem_q;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    run_mode_d  = run_mode_q;
    end_phase_d = end_phase_q;
    run_len_d   = run_len_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    rd_d        = rd_q;
    rem_d       = rem_q;
    chk_d       = chk_q;
    hdr_d       = hdr_q;
    cmd_o         = '0;
    cmd_o.bsel    = pbrle_pkg::BSEL_HDR;
    cmd_o.wsel    = pbrle_pkg::WSEL_BYTE;
    cmd_o.hdr     = hdr_q;
    cmd_o.raddr   = rd_q;
    cmd_o.waddr   = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (run_mode_q) begin
          if (sts_i.eq_rv) begin
            if (run_len_q == 8'(pbrle_pkg::MaxChunk)) begin
              hdr_d     = 8'd1 - 8'(pbrle_pkg::MaxChunk);
              run_len_d = 8'd1;
              state_d   = S_RUN_HDR;
            end else begin
              run_len_d = run_len_q + 8'd1;
              state_d   = S_FIN;
            end
          end else begin
            run_mode_d = 1'b0;
            run_len_d  = '0;
            cmd_o.we   = 1'b1;
            if (run_len_q >= 8'd2) begin
              hdr_d   = 8'd1 - run_len_q;
              cnt_d   = 8'd1;
              state_d = S_RUN_HDR;
            end else begin
              // single leftover run byte opens the literal
              cmd_o.wsel = pbrle_pkg::WSEL_RUNV;
              cnt_d      = 8'd2;
              state_d    = S_WR2;
            end
          end
        end else begin
          cmd_o.we    = 1'b1;
          cmd_o.waddr = head_q + cnt_q;
          if (cnt_q >= 8'd2 && sts_i.eq_p1 && sts_i.eq_p2) begin
            cmd_o.rv_load = 1'b1;
            run_mode_d    = 1'b1;
            run_len_d     = 8'd3;
            cnt_d         = '0;
            rem_d         = cnt_q - 8'd2;
            rd_d          = head_q;
            state_d       = (cnt_q == 8'd2) ? S_FIN : S_LIT_HDR;
          end else if (cnt_q >= 8'(pbrle_pkg::MaxChunk + 1)) begin
            rem_d   = 8'(pbrle_pkg::MaxChunk);
            rd_d    = head_q;
            head_d  = head_q + 8'(pbrle_pkg::MaxChunk);
            cnt_d   = cnt_q + 8'd1 - 8'(pbrle_pkg::MaxChunk);
            state_d = S_LIT_HDR;
          end else begin
            cnt_d   = cnt_q + 8'd1;
            state_d = S_FIN;
          end
        end
      end
      S_WR2: begin
        cmd_o.we    = 1'b1;
        cmd_o.waddr = head_q + 8'd1;
        state_d     = S_FIN;
      end
      S_RUN_HDR: begin
        if (sts_i.byte_rdy) begin
          cmd_o.push = 1'b1;
          state_d    = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (sts_i.byte_rdy) begin
          cmd_o.push = 1'b1;
          cmd_o.bsel = pbrle_pkg::BSEL_RUNV;
          state_d    = end_phase_q ? S_FLUSH : S_FIN;
        end
      end
      S_LIT_HDR: begin
        cmd_o.hdr = chunk - 8'd1;
        if (sts_i.byte_rdy) begin
          cmd_o.push = 1'b1;
          chk_d      = chunk;
          state_d    = S_LIT_RD;
        end
      end
      S_LIT_RD: begin
        state_d = S_LIT_EM;
      end
      S_LIT_EM: begin
        if (sts_i.byte_rdy) begin
          cmd_o.push = 1'b1;
          cmd_o.bsel = pbrle_pkg::BSEL_MEM;
          rd_d       = rd_q + 8'd1;
          rem_d      = rem_q - 8'd1;
          chk_d      = chk_q - 8'd1;
          if (chk_q != 8'd1)      state_d = S_LIT_RD;
          else if (rem_q != 8'd1) state_d = S_LIT_HDR;
          else                    state_d = end_phase_q ? S_FLUSH : S_FIN;
        end
      end
      S_FIN: begin
        end_phase_d = 1'b1;
        state_d     = S_FLUSH;
        if (sts_i.line_end) begin
          run_mode_d = 1'b0;
          run_len_d  = '0;
          cnt_d      = '0;
          if (run_mode_q && run_len_q >= 8'd2) begin
            hdr_d   = 8'd1 - run_len_q;
            state_d = S_RUN_HDR;
          end else if (run_mode_q) begin
            // lone run byte goes out as a one-byte literal
            cmd_o.we   = 1'b1;
            cmd_o.wsel = pbrle_pkg::WSEL_RUNV;
            rem_d      = 8'd1;
            rd_d       = head_q;
            state_d    = S_LIT_HDR;
          end else if (cnt_q != 8'd0) begin
            rem_d   = cnt_q;
            rd_d    = head_q;
            state_d = S_LIT_HDR;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.pk_empty) begin
          end_phase_d = 1'b0;
          state_d     = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          end_phase_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_mode_q  <= 1'b0;
      end_phase_q <= 1'b0;
      run_len_q   <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      rd_q        <= '0;
      rem_q       <= '0;
      chk_q       <= '0;
      hdr_q       <= '0;
    end else begin
      state_q     <= state_d;
      run_mode_q  <= run_mode_d;
      end_phase_q <= end_phase_d;
      run_len_q   <= run_len_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      rd_q        <= rd_d;
      rem_q       <= rem_d;
      chk_q       <= chk_d;
      hdr_q       <= hdr_d;
    end
  end

endmodule

`default_nettype wire

@@ design/packbits_run_length_encoder_core.sv @@
// Channel | Dir | Payload                                          | Transfer
// in_i    | in  | data_byte[7:0], line_end                         | valid & ready
// out_o   | out | packed_bytes[63:0], byte_count[3:0],             | valid & ready
//         |     | last_of_item, line_done                          |
//
// One input byte passes through accept, evaluate, end check and flush when
// it codes nothing; a single leftover run byte must also be stored after
// evaluate. Each header or run byte adds a pack step, and each literal byte
// read back from the pending-byte memory adds a read step, then a pack step.
// Reset clears the controller state and the packer; the pending memory needs
// no clearing. A stalled output holds the packer, which holds the controller.
`default_nettype none

module packbits_run_length_encoder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pbrle_in_if.sink    in_i,
  pbrle_out_if.source out_o
);

  pbrle_pkg::cmd_t cmd;
  pbrle_pkg::sts_t sts;
  logic            in_ready;
  logic            in_fire;

  // Accept a new byte only while the controller is idle.
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  // Sequence segment decisions and byte emission.
  pbrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold pending bytes, run value, packer and output register.
  pbrle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .data_byte_i    (in_i.data_byte),
    .line_end_i     (in_i.line_end),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .packed_bytes_o (out_o.packed_bytes),
    .byte_count_o   (out_o.byte_count),
    .last_of_item_o (out_o.last_of_item),
    .line_done_o    (out_o.line_done)
  );

endmodule

`default_nettype wire

@@ design/pbrle_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module pbrle_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] packed_bytes_i,
  input wire logic [3:0]  byte_count_i,
  input wire logic        last_of_item_i,
  input wire logic        line_done_i
);

  `PB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `PB_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_i, byte_count_i != 4'd0 && byte_count_i <= 4'd8, "byte count out of range")
  `PB_ASSERT_IMP(a_done_last, clk_i, rst_ni, out_valid_i && line_done_i, last_of_item_i, "line end not on last result")
  `PB_ASSERT_IMP(a_top_zero, clk_i, rst_ni, out_valid_i && byte_count_i != 4'd8, packed_bytes_i[63:56] == 8'd0, "stale bytes above count")
  `PB_ASSERT_IMP(a_busy_partial, clk_i, rst_ni, out_valid_i && !last_of_item_i, byte_count_i == 4'd8 && !in_ready_i, "partial result mid item")

endmodule

bind packbits_run_length_encoder_core pbrle_checker u_pbrle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .packed_bytes_i (out_o.packed_bytes),
  .byte_count_i   (out_o.byte_count),
  .last_of_item_i (out_o.last_of_item),
  .line_done_i    (out_o.line_done)
);

`default_nettype wire
